// ===== rtl/flrr_pkg.sv =====
`timescale 1ns / 1ps

package flrr_pkg;

  // ring and line sizes
  localparam int RING_BYTES = 4096;
  localparam int LINE_BYTES = 256;

  localparam int RING_AW = $clog2(RING_BYTES);
  localparam int USED_W  = RING_AW + 1;
  localparam int LINE_AW = $clog2(LINE_BYTES);

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 3;
  localparam int IDX_W   = 12;
  localparam int COUNT_W = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // width for offset add and compare against the used count
  localparam int SUM_W = ((IDX_W > USED_W) ? IDX_W : USED_W) + 1;

  localparam logic [LEVEL_W-1:0] CAP_RESET = 3'd3;

  // character codes
  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_M   = 8'h6d;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_DOT = 8'h2e;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOG   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_REARM = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CM_RD,
    ST_CM_WR,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  // display form of a stored byte
  function automatic logic [BYTE_W-1:0] sanitize(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c != CH_LF && (c < CH_SP || c >= CH_DEL)) begin
      r = CH_DOT;
    end
    return r;
  endfunction

endpackage

// ===== rtl/filtered_log_ring_recorder.sv =====
`timescale 1ns / 1ps

// Filtered log ring recorder.
// Input channel (in_valid/in_ready) carries one request: a log byte, a ring
// read or a rearm. Log bytes whose level is 0 or above capture_level are
// dropped; others are stripped of escape runs and CRs and gathered into a
// line store. The last byte of a message, if kept, copies the line plus a
// newline into the byte ring through the single line/ring copy path, each
// line byte read from the line store, then written to the ring, and the
// newline last; in_ready is low meanwhile. A plain log byte or a rearm is
// handled as it is taken. A read request goes through offset add and ring
// read, then sanitize into the output register. Only reads produce a result
// on out_valid/out_ready. The output register holds a result until out_ready;
// a following request is accepted while it waits, but a second read stalls
// in its last step until the first result is taken.
// Reset (rst_n low, synchronous) empties ring and line and sets
// capture_level to 3; ring and line memories are not cleared, since an entry
// is only read after it has been written. capture_level sits at APB address 0.
module filtered_log_ring_recorder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [flrr_pkg::PADDR_W-1:0]    paddr,
  input  logic [flrr_pkg::PDATA_W-1:0]    pwdata,
  output logic [flrr_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [flrr_pkg::CMD_W-1:0]      in_cmd,
  input  logic [flrr_pkg::BYTE_W-1:0]     in_log_byte,
  input  logic [flrr_pkg::LEVEL_W-1:0]    in_log_level,
  input  logic                            in_log_last,
  input  logic [flrr_pkg::IDX_W-1:0]      in_read_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [flrr_pkg::BYTE_W-1:0]     out_read_byte,
  output logic                            out_read_valid,
  output logic [flrr_pkg::COUNT_W-1:0]    out_bytes_used
);
  import flrr_pkg::*;

  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_BYTES - 1);
  localparam logic [USED_W-1:0]  RING_FULL = USED_W'(RING_BYTES);
  localparam logic [LINE_AW-1:0] LINE_MAX  = LINE_AW'(LINE_BYTES - 1);
  localparam logic [SUM_W-1:0]   RING_SUM  = SUM_W'(RING_BYTES);

  state_t               state_r, state_nxt;
  logic [LEVEL_W-1:0]   cap_r, cap_nxt;
  logic [RING_AW-1:0]   wp_r, wp_nxt;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic [LINE_AW-1:0]   line_len_r, line_len_nxt;
  logic                 esc_r, esc_nxt;
  logic [LINE_AW-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                 out_rv_r, out_rv_nxt;
  logic [COUNT_W-1:0]   out_used_r, out_used_nxt;

  // memories
  logic [BYTE_W-1:0]    ring_mem [RING_BYTES];
  logic [BYTE_W-1:0]    line_mem [LINE_BYTES];
  logic [BYTE_W-1:0]    ring_rdata_r;
  logic [BYTE_W-1:0]    line_rdata_r;

  logic                 ring_we, ring_re, line_we, line_re;
  logic [RING_AW-1:0]   ring_raddr;
  logic [BYTE_W-1:0]    ring_wdata, line_wdata;

  logic                 in_take, out_load, cfg_wr, keep;
  logic [SUM_W-1:0]     from_ext, pos_sum;
  cmd_t                 cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = (state_r == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign keep     = (in_log_level != '0) && (in_log_level <= cap_r);
  assign cfg_wr   = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == 1'b0) ? PDATA_W'(cap_r) : '0;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr) begin
      cap_nxt = pwdata[LEVEL_W-1:0];
    end
  end

  // oldest-first offset into ring position
  assign from_ext = (used_r == RING_FULL) ? SUM_W'(wp_r) : '0;
  always_comb begin
    pos_sum = from_ext + SUM_W'(idx_r);
    if (pos_sum >= RING_SUM) begin
      pos_sum = pos_sum - RING_SUM;
    end
  end

  // sequencer and datapath control
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    used_nxt      = used_r;
    line_len_nxt  = line_len_r;
    esc_nxt       = esc_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_rv_nxt    = out_rv_r;
    out_used_nxt  = out_used_r;
    ring_we       = 1'b0;
    ring_wdata    = line_rdata_r;
    ring_re       = 1'b0;
    ring_raddr    = RING_AW'(pos_sum);
    line_we       = 1'b0;
    line_wdata    = in_log_byte;
    line_re       = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (cmd)
            CMD_LOG: begin
              if (!keep) begin
                if (in_log_last) begin
                  line_len_nxt = '0;
                  esc_nxt      = 1'b0;
                end
              end else begin
                // filter one accepted byte into the line
                if (line_len_r != LINE_MAX) begin
                  if (esc_r) begin
                    if (in_log_byte == CH_M) begin
                      esc_nxt = 1'b0;
                    end
                  end else if (in_log_byte == CH_ESC) begin
                    esc_nxt = 1'b1;
                  end else if (in_log_byte != CH_CR) begin
                    line_we      = 1'b1;
                    line_wdata   = (in_log_byte == CH_LF) ? CH_SP : in_log_byte;
                    line_len_nxt = line_len_r + 1'b1;
                  end
                end
                if (in_log_last) begin
                  cnt_nxt   = '0;
                  state_nxt = ST_CM_RD;
                end
              end
            end
            CMD_READ: begin
              idx_nxt   = in_read_index;
              state_nxt = ST_RD_ADDR;
            end
            CMD_REARM: begin
              wp_nxt   = '0;
              used_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CM_RD: begin
        if (cnt_r == line_len_r) begin
          // closing newline ends the commit
          ring_we      = 1'b1;
          ring_wdata   = CH_LF;
          wp_nxt       = (wp_r == RING_LAST) ? '0 : wp_r + 1'b1;
          used_nxt     = (used_r == RING_FULL) ? used_r : used_r + 1'b1;
          line_len_nxt = '0;
          esc_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end else begin
          line_re   = 1'b1;
          state_nxt = ST_CM_WR;
        end
      end
      ST_CM_WR: begin
        // copy one line byte into the ring
        ring_we   = 1'b1;
        wp_nxt    = (wp_r == RING_LAST) ? '0 : wp_r + 1'b1;
        used_nxt  = (used_r == RING_FULL) ? used_r : used_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_CM_RD;
      end
      ST_RD_ADDR: begin
        ring_re   = 1'b1;
        rd_ok_nxt = SUM_W'(idx_r) < SUM_W'(used_r);
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_ok_r ? sanitize(ring_rdata_r) : '0;
          out_rv_nxt    = rd_ok_r;
          out_used_nxt  = COUNT_W'(used_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      wp_r        <= '0;
      used_r      <= '0;
      line_len_r  <= '0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      wp_r        <= wp_nxt;
      used_r      <= used_nxt;
      line_len_r  <= line_len_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_byte_r <= out_byte_nxt;
    out_rv_r   <= out_rv_nxt;
    out_used_r <= out_used_nxt;
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_r <= ring_mem[ring_raddr];
    end
  end

  // line memory
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_len_r] <= line_wdata;
    end
    if (line_re) begin
      line_rdata_r <= line_mem[cnt_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_byte  = out_byte_r;
  assign out_read_valid = out_rv_r;
  assign out_bytes_used = out_used_r;

`ifndef SYNTH
  // used count never passes the ring size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= RING_FULL)
    else $error("used count above ring size");

  // commit copy never runs past the gathered line
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CM_RD || state_r == ST_CM_WR) |-> cnt_r <= line_len_r)
    else $error("commit index past line length");

  // a finished read shows up as a result in the next cycle
  a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("read result not presented");

  // output held while receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_byte_r))
    else $error("stalled result changed");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import flrr_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 7;
  // worst commit copies a full line, a read and a write per byte, plus the newline
  localparam int SETTLE_CYCLES = 2 * LINE_BYTES + 64;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [PADDR_W-1:0] CAPTURE_LEVEL_ADDR = '0;

  typedef struct packed {
    logic [BYTE_W-1:0]  rd_byte;
    logic               rd_valid;
    logic [COUNT_W-1:0] used;
  } ring_read_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [BYTE_W-1:0]  lbyte;
    logic [LEVEL_W-1:0] lvl;
    logic               last;
    logic [IDX_W-1:0]   idx;
    logic               has_lit;
    ring_read_t         lit;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd;
  logic [BYTE_W-1:0]   in_log_byte;
  logic [LEVEL_W-1:0]  in_log_level;
  logic                in_log_last;
  logic [IDX_W-1:0]    in_read_index;
  logic                out_valid;
  logic                out_ready;
  logic [BYTE_W-1:0]   out_read_byte;
  logic                out_read_valid;
  logic [COUNT_W-1:0]  out_bytes_used;

  filtered_log_ring_recorder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_log_byte    (in_log_byte),
    .in_log_level   (in_log_level),
    .in_log_last    (in_log_last),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_byte  (out_read_byte),
    .out_read_valid (out_read_valid),
    .out_bytes_used (out_bytes_used)
  );

  // recorder image kept by the testbench
  bit [BYTE_W-1:0]    ring_img [RING_BYTES];
  bit [BYTE_W-1:0]    line_img [LINE_BYTES];
  int unsigned        wr_pos = 0;
  int unsigned        used_bytes = 0;
  int unsigned        line_len = 0;
  bit                 esc_active = 1'b0;
  logic [LEVEL_W-1:0] cap_level = CAP_RESET;

  ring_read_t pending_reads[$];
  ring_read_t got_read;
  ring_read_t want_read;
  stim_row_t  directed[$];
  int         fail_count = 0;
  int         sent_count = 0;
  bit         idle_enable = 1'b1;
  bit         msg_gaps = 1'b1;
  bit         rx_quiet = 1'b0;
  bit         hold_long = 1'b0;

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // safety net
  initial begin
    #(64'd10_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic void ring_append(input logic [BYTE_W-1:0] c);
    ring_img[wr_pos] = c;
    wr_pos = (wr_pos + 1) % RING_BYTES;
    if (used_bytes < RING_BYTES) used_bytes++;
  endfunction

  // update the image for one accepted request, queue the read result
  function automatic void record_request(input cmd_t c, input logic [BYTE_W-1:0] b,
                                         input logic [LEVEL_W-1:0] lvl, input logic last,
                                         input logic [IDX_W-1:0] idx, input logic has_lit,
                                         input ring_read_t lit);
    ring_read_t        res;
    int unsigned       pos;
    logic [BYTE_W-1:0] ch;
    int                i;
    res = '0;
    case (c)
      CMD_LOG: begin
        if (lvl == 0 || lvl > cap_level) begin
          // dropped byte still marks the message boundary
          if (last) begin
            line_len = 0;
            esc_active = 1'b0;
          end
        end else begin
          if (line_len < LINE_BYTES - 1) begin
            if (esc_active) begin
              if (b == CH_M) esc_active = 1'b0;
            end else if (b == CH_ESC) begin
              esc_active = 1'b1;
            end else if (b != CH_CR) begin
              line_img[line_len] = (b == CH_LF) ? CH_SP : b;
              line_len++;
            end
          end
          if (last) begin
            for (i = 0; i < line_len; i++) ring_append(line_img[i]);
            ring_append(CH_LF);
            line_len = 0;
            esc_active = 1'b0;
          end
        end
      end
      CMD_READ: begin
        if (idx < used_bytes) begin
          pos = (((used_bytes >= RING_BYTES) ? wr_pos : 0) + idx) % RING_BYTES;
          ch = ring_img[pos];
          if (ch != CH_LF && (ch < CH_SP || ch >= CH_DEL)) ch = CH_DOT;
          res.rd_byte = ch;
          res.rd_valid = 1'b1;
        end
        res.used = COUNT_W'(used_bytes);
        pending_reads.push_back(has_lit ? lit : res);
      end
      CMD_REARM: begin
        wr_pos = 0;
        used_bytes = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic stim_row_t log_row(input logic [BYTE_W-1:0] b,
                                        input logic [LEVEL_W-1:0] lvl, input logic last);
    return '{CMD_LOG, b, lvl, last, IDX_W'($urandom_range(0, 4095)), 1'b0, ring_read_t'('0)};
  endfunction

  function automatic stim_row_t cmd_row(input cmd_t c, input logic [IDX_W-1:0] idx,
                                        input logic has_lit, input ring_read_t lit);
    return '{c, BYTE_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 7)),
             1'($urandom_range(0, 1)), idx, has_lit, lit};
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(input cmd_t c, input logic [BYTE_W-1:0] b,
                              input logic [LEVEL_W-1:0] lvl, input logic last,
                              input logic [IDX_W-1:0] idx, input logic has_lit,
                              input ring_read_t lit);
    int gap;
    gap = 0;
    if (idle_enable && msg_gaps && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_log_byte   <= b;
    in_log_level  <= lvl;
    in_log_last   <= last;
    in_read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    record_request(c, b, lvl, last, idx, has_lit, lit);
    sent_count++;
  endtask

  // read index mostly inside the used range, some at its edge, some anywhere
  task automatic send_read();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    if (used_bytes > 0 && pick < 70) idx = $urandom_range(0, used_bytes - 1);
    else if (pick < 85) idx = (used_bytes + $urandom_range(0, 3) > 4095) ? 4095 :
                              used_bytes + $urandom_range(0, 3);
    else idx = $urandom_range(0, 4095);
    send_request(CMD_READ, BYTE_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)), IDX_W'(idx), 1'b0, '0);
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // apb write of capture_level once the block is idle
  task automatic set_capture_level(input logic [LEVEL_W-1:0] lvl);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPTURE_LEVEL_ADDR;
    pwdata  <= PDATA_W'(lvl);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_level = lvl;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random traffic: mostly whole messages, with reads, rearms and noise mixed in
  task automatic run_phase(input logic [LEVEL_W-1:0] lvl, input int n_items,
                           input bit long_msgs, input bit hold_rx);
    int                 start;
    int                 len;
    int                 pick;
    int                 k;
    logic [LEVEL_W-1:0] msg_lvl;
    logic [BYTE_W-1:0]  b;
    set_capture_level(lvl);
    start = sent_count;
    if (hold_rx) hold_long = 1'b1;
    while (sent_count - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        msg_gaps = ($urandom_range(0, 2) != 0);
        msg_lvl = (cap_level != 0 && $urandom_range(0, 4) != 0) ?
                  LEVEL_W'($urandom_range(1, cap_level)) : LEVEL_W'($urandom_range(0, 7));
        if (long_msgs || $urandom_range(0, 9) == 0) len = $urandom_range(200, 300);
        else len = $urandom_range(1, 24);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) send_read();
          // broken message: level changes part way
          if (!long_msgs && $urandom_range(0, 24) == 0) msg_lvl = LEVEL_W'($urandom_range(0, 7));
          case ($urandom_range(0, long_msgs ? 63 : 15))
            0:       b = CH_ESC;
            1:       b = CH_M;
            2:       b = CH_CR;
            3:       b = CH_LF;
            4:       b = BYTE_W'($urandom_range(0, 255));
            default: b = BYTE_W'($urandom_range(8'h20, 8'h7e));
          endcase
          send_request(CMD_LOG, b, msg_lvl, k == len - 1, IDX_W'($urandom_range(0, 4095)),
                       1'b0, '0);
        end
        // sender pause until every result is back
        if ($urandom_range(0, 39) == 0) begin
          park_input();
          wait_drained();
        end
      end else if (pick < 85) begin
        send_read();
      end else if (pick < 92 && !long_msgs) begin
        send_request(CMD_REARM, BYTE_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 4095)), 1'b0, '0);
      end else if (pick < 95) begin
        send_request(CMD_NOP, BYTE_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 4095)), 1'b0, '0);
      end else begin
        // stray log byte outside any message pattern
        send_request(CMD_LOG, BYTE_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 4095)), 1'b0, '0);
      end
    end
    park_input();
    msg_gaps = 1'b1;
  endtask

  // result side: short stalls, quiet stretches, one long hold-off
  initial begin : rx_side
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        out_ready <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each taken result with the oldest expected read
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_read = '{out_read_byte, out_read_valid, out_bytes_used};
      if (pending_reads.size() == 0) begin
        $error("unexpected result: read_byte %0h read_valid %0b bytes_used %0d",
               got_read.rd_byte, got_read.rd_valid, got_read.used);
        fail_count++;
      end else begin
        want_read = pending_reads.pop_front();
        if (got_read.rd_byte !== want_read.rd_byte) begin
          $error("read_byte: expected %0h, got %0h", want_read.rd_byte, got_read.rd_byte);
          fail_count++;
        end
        if (got_read.rd_valid !== want_read.rd_valid) begin
          $error("read_valid: expected %0b, got %0b", want_read.rd_valid, got_read.rd_valid);
          fail_count++;
        end
        if (got_read.used !== want_read.used) begin
          $error("bytes_used: expected %0d, got %0d", want_read.used, got_read.used);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_cmd        = CMD_NOP;
    in_log_byte   = '0;
    in_log_level  = '0;
    in_log_last   = 1'b0;
    in_read_index = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset capture level
    directed.push_back(cmd_row(CMD_READ, 12'd0, 1'b1, '{8'h00, 1'b0, 13'd0}));
    directed.push_back(cmd_row(CMD_READ, 12'hfff, 1'b1, '{8'h00, 1'b0, 13'd0}));
    directed.push_back(log_row(8'h41, 3'd1, 1'b0));   // 'A'
    directed.push_back(log_row(CH_ESC, 3'd2, 1'b0));  // escape run
    directed.push_back(log_row(8'h5b, 3'd2, 1'b0));   // '['
    directed.push_back(log_row(CH_M, 3'd2, 1'b0));    // run ends
    directed.push_back(log_row(CH_CR, 3'd3, 1'b0));
    directed.push_back(log_row(CH_LF, 3'd3, 1'b0));   // becomes a space
    directed.push_back(log_row(8'hff, 3'd3, 1'b0));
    directed.push_back(log_row(8'h00, 3'd1, 1'b0));
    directed.push_back(log_row(CH_DEL, 3'd1, 1'b0));
    directed.push_back(log_row(8'h7a, 3'd4, 1'b0));   // above capture level
    directed.push_back(log_row(8'h42, 3'd0, 1'b0));   // level zero
    directed.push_back(log_row(8'h43, 3'd3, 1'b1));   // commit
    directed.push_back(cmd_row(CMD_READ, 12'd0, 1'b0, '0));
    directed.push_back(cmd_row(CMD_READ, 12'd6, 1'b0, '0));
    directed.push_back(cmd_row(CMD_READ, 12'd7, 1'b1, '{8'h00, 1'b0, 13'd7}));
    // escape left open at message end
    directed.push_back(log_row(CH_ESC, 3'd1, 1'b0));
    directed.push_back(log_row(8'h78, 3'd1, 1'b1));
    // dropped final byte closes the message without a commit
    directed.push_back(log_row(8'h51, 3'd1, 1'b0));
    directed.push_back(log_row(8'h52, 3'd7, 1'b1));
    // rearm keeps the line being gathered
    directed.push_back(log_row(8'h4b, 3'd1, 1'b0));
    directed.push_back(cmd_row(CMD_REARM, 12'd0, 1'b0, '0));
    directed.push_back(log_row(8'h4c, 3'd1, 1'b1));
    directed.push_back(cmd_row(CMD_READ, 12'd0, 1'b0, '0));
    directed.push_back(cmd_row(CMD_NOP, 12'd0, 1'b0, '0));
    foreach (directed[i]) begin
      send_request(directed[i].cmd, directed[i].lbyte, directed[i].lvl, directed[i].last,
                   directed[i].idx, directed[i].has_lit, directed[i].lit);
    end
    park_input();

    // long lines run into the line length limit
    run_phase(3'd7, 700, 1'b1, 1'b0);
    run_phase(3'd0, 80, 1'b0, 1'b0);
    run_phase(3'd1, 200, 1'b0, 1'b0);
    run_phase(3'd5, 250, 1'b0, 1'b1);
    run_phase(3'd2, 200, 1'b0, 1'b0);
    idle_enable = 1'b0;
    rx_quiet = 1'b1;
    run_phase(3'd7, 250, 1'b0, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reads.size() != 0) begin
      $error("%0d read results never arrived", pending_reads.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
